>>> sv/gptf_pkg.sv
// ----------------------------------------------------------------------------
// gptf_pkg: shared types and constants
// Types and constants for the gated pose/twist fusion block.
// ----------------------------------------------------------------------------
package gptf_pkg;

  localparam int QUAT_BITS = 18;
  localparam int TOL_BITS  = 23;
  localparam int SRC_BITS  = 3;
  localparam int Q_ONE     = 65536;

  // request kinds
  typedef enum logic [1:0] {
    REQ_LIDAR = 2'd0,
    REQ_GNSS  = 2'd1,
    REQ_CAN   = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // result source codes
  typedef enum logic [2:0] {
    SRC_LIDAR_ONLY = 3'd0,
    SRC_GNSS_ONLY  = 3'd1,
    SRC_AVERAGED   = 3'd2,
    SRC_LIDAR_PICK = 3'd3,
    SRC_GNSS_PICK  = 3'd4
  } src_t;

  // configuration register indexes
  localparam logic CFG_SPEED_TOL = 1'b0;
  localparam logic CFG_YAW_TOL   = 1'b1;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_NORM,
    BE_SQRT,
    BE_DIV,
    BE_OUT
  } be_state_t;

endpackage

>>> sv/gptf_front.sv
// ----------------------------------------------------------------------------
// gptf_front: sample store and tick classification
// Keeps the latest lidar, gnss and CAN samples, checks both sources against
// CAN and forms the job for the back end (copy, pick or average).
// ----------------------------------------------------------------------------
module gptf_front
  import gptf_pkg::*;
#(
  parameter int PB = 32,
  parameter int RB = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               req,
  input  logic [3*PB-1:0]          pos,
  input  logic [4*QUAT_BITS-1:0]   att,
  input  logic [2*RB-1:0]          mot,
  input  logic [TOL_BITS-1:0]      spd_tol,
  input  logic [TOL_BITS-1:0]      yaw_tol,
  output logic                     job_valid,
  input  logic                     job_ready,
  output logic [3*PB-1:0]          job_pos,
  output logic [4*QUAT_BITS-1:0]   job_att0,
  output logic [4*QUAT_BITS-1:0]   job_att1,
  output logic [2*RB-1:0]          job_mot,
  output logic [SRC_BITS-1:0]      job_src
);

  logic                    lid_pres_r, gns_pres_r;
  logic [3*PB-1:0]         lid_pos_r, gns_pos_r;
  logic [4*QUAT_BITS-1:0]  lid_att_r, gns_att_r;
  logic [2*RB-1:0]         lid_mot_r, gns_mot_r;
  logic [2*RB-1:0]         can_r;
  logic                    jv_r;
  logic [3*PB-1:0]         jpos_r;
  logic [4*QUAT_BITS-1:0]  ja0_r, ja1_r;
  logic [2*RB-1:0]         jmot_r;
  logic [SRC_BITS-1:0]     jsrc_r;
  logic                    acc;
  logic                    lok, gok;
  logic [3*PB-1:0]         avg_pos;
  logic [2*RB-1:0]         avg_mot;
  logic                    emit;
  src_t                    code;

  // tolerance check at full width
  function automatic logic pass_chk(input logic [2*RB-1:0] m,
                                    input logic [2*RB-1:0] c,
                                    input logic [TOL_BITS-1:0] ts,
                                    input logic [TOL_BITS-1:0] ty);
    logic signed [RB:0] ds, dy;
    logic [RB:0] as, ay;
    ds = $signed({m[RB-1], m[RB-1:0]}) - $signed({c[RB-1], c[RB-1:0]});
    dy = $signed({m[2*RB-1], m[2*RB-1:RB]}) - $signed({c[2*RB-1], c[2*RB-1:RB]});
    as = ds[RB] ? (RB+1)'(-ds) : ds;
    ay = dy[RB] ? (RB+1)'(-dy) : dy;
    return ((RB+TOL_BITS+1)'(as) <= (RB+TOL_BITS+1)'(ts)) &&
           ((RB+TOL_BITS+1)'(ay) <= (RB+TOL_BITS+1)'(ty));
  endfunction

  assign in_ready = !jv_r || job_ready;
  assign acc      = in_valid && in_ready;
  assign lok      = pass_chk(lid_mot_r, can_r, spd_tol, yaw_tol);
  assign gok      = pass_chk(gns_mot_r, can_r, spd_tol, yaw_tol);

  // floor averages of position and motion
  always_comb begin
    logic signed [PB:0] sp;
    logic signed [RB:0] sm;
    avg_pos = '0;
    avg_mot = '0;
    for (int i = 0; i < 3; i++) begin
      sp = $signed({lid_pos_r[i*PB+PB-1], lid_pos_r[i*PB +: PB]}) +
           $signed({gns_pos_r[i*PB+PB-1], gns_pos_r[i*PB +: PB]});
      avg_pos[i*PB +: PB] = sp[PB:1];
    end
    for (int i = 0; i < 2; i++) begin
      sm = $signed({lid_mot_r[i*RB+RB-1], lid_mot_r[i*RB +: RB]}) +
           $signed({gns_mot_r[i*RB+RB-1], gns_mot_r[i*RB +: RB]});
      avg_mot[i*RB +: RB] = sm[RB:1];
    end
  end

  // tick classification
  always_comb begin
    emit = lid_pres_r || gns_pres_r;
    if (lid_pres_r && !gns_pres_r) begin
      code = SRC_LIDAR_ONLY;
    end else if (!lid_pres_r) begin
      code = SRC_GNSS_ONLY;
    end else if (lok && gok) begin
      code = SRC_AVERAGED;
    end else if (!lok) begin
      code = SRC_GNSS_PICK;
    end else begin
      code = SRC_LIDAR_PICK;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lid_pres_r <= 1'b0;
      gns_pres_r <= 1'b0;
      can_r      <= '0;
      jv_r       <= 1'b0;
    end else begin
      if (job_ready) jv_r <= 1'b0;
      if (acc) begin
        case (req_t'(req))
          REQ_LIDAR: lid_pres_r <= 1'b1;
          REQ_GNSS:  gns_pres_r <= 1'b1;
          REQ_CAN:   can_r <= mot;
          REQ_TICK:  jv_r <= emit;
          default:   ;
        endcase
      end
    end
  end

  // sample and job payload
  always_ff @(posedge clk) begin
    if (acc && req_t'(req) == REQ_LIDAR) begin
      lid_pos_r <= pos; lid_att_r <= att; lid_mot_r <= mot;
    end
    if (acc && req_t'(req) == REQ_GNSS) begin
      gns_pos_r <= pos; gns_att_r <= att; gns_mot_r <= mot;
    end
    if (acc && req_t'(req) == REQ_TICK) begin
      jsrc_r <= code;
      case (code)
        SRC_LIDAR_ONLY, SRC_LIDAR_PICK: begin
          jpos_r <= lid_pos_r; ja0_r <= lid_att_r; ja1_r <= '0; jmot_r <= lid_mot_r;
        end
        SRC_AVERAGED: begin
          jpos_r <= avg_pos; ja0_r <= lid_att_r; ja1_r <= gns_att_r; jmot_r <= avg_mot;
        end
        default: begin
          jpos_r <= gns_pos_r; ja0_r <= gns_att_r; ja1_r <= '0; jmot_r <= gns_mot_r;
        end
      endcase
    end
  end

  assign job_valid = jv_r;
  assign job_pos   = jpos_r;
  assign job_att0  = ja0_r;
  assign job_att1  = ja1_r;
  assign job_mot   = jmot_r;
  assign job_src   = jsrc_r;

endmodule

>>> sv/gptf_back.sv
// ----------------------------------------------------------------------------
// gptf_back: quaternion normalization and result register
// Sums the squares one component a cycle, takes an iterative square root,
// then divides each component by restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module gptf_back
  import gptf_pkg::*;
#(
  parameter int PB = 32,
  parameter int RB = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  logic [3*PB-1:0]          job_pos,
  input  logic [4*QUAT_BITS-1:0]   job_att0,
  input  logic [4*QUAT_BITS-1:0]   job_att1,
  input  logic [2*RB-1:0]          job_mot,
  input  logic [SRC_BITS-1:0]      job_src,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [3*PB-1:0]          res_pos,
  output logic [4*QUAT_BITS-1:0]   res_att,
  output logic [2*RB-1:0]          res_mot,
  output logic [SRC_BITS-1:0]      res_src
);

  localparam int SB = QUAT_BITS + 1;   // summed component width
  localparam int MB = 2 * SB;          // square width
  localparam int NB = 64;              // square-root operand width
  localparam int LB = 32;              // root width
  localparam int DB = 48;              // dividend width
  localparam logic [5:0] SQ_LAST  = 6'd31;  // last root step
  localparam logic [5:0] DIV_LAST = 6'd49;  // load, 48 steps, write

  be_state_t               st_r, st_nxt;
  logic [SB*4-1:0]         s_r;
  logic [3*PB-1:0]         pos_r;
  logic [2*RB-1:0]         mot_r;
  logic [SRC_BITS-1:0]     src_r;
  logic [4*QUAT_BITS-1:0]  q_r;
  logic [39:0]             n_r;
  logic [NB-1:0]           rad_r;
  logic [LB-1:0]           root_r;
  logic [LB+1:0]           rem_r;
  logic [DB-1:0]           dnd_r;
  logic [5:0]              cnt_r;
  logic [1:0]              idx_r;
  logic                    job_acc, res_acc;
  logic                    copy_job;
  logic signed [SB-1:0]    cur;
  logic [SB-1:0]           cur_abs;
  logic [MB-1:0]           sq;
  logic [39:0]             n_sum;
  logic [LB+3:0]           rt_hi, rt_try;
  logic [LB+1:0]           dv_sh, dv_den;
  logic                    dv_ge;
  logic [QUAT_BITS-1:0]    k_val;

  assign job_acc  = job_valid && job_ready;
  assign res_acc  = res_valid && res_ready;
  assign copy_job = (job_src == SRC_LIDAR_ONLY) || (job_src == SRC_GNSS_ONLY);
  assign cur      = $signed(s_r[idx_r*SB +: SB]);
  assign cur_abs  = cur[SB-1] ? SB'(-cur) : SB'(cur);

  // sum of squares
  assign sq    = MB'(cur_abs) * MB'(cur_abs);
  assign n_sum = n_r + 40'(sq);

  // root step: remainder with next bit pair against 4*root+1
  assign rt_hi  = {rem_r, rad_r[NB-1 -: 2]};
  assign rt_try = (LB+4)'({root_r, 2'b01});

  // division step with rounding: (a<<29 + L) / (2L)
  assign dv_sh  = {rem_r[LB:0], dnd_r[DB-1]};
  assign dv_den = (LB+2)'({root_r, 1'b0});
  assign dv_ge  = dv_sh >= dv_den;

  // quotient clamped to one
  assign k_val = (dnd_r > DB'(Q_ONE)) ? QUAT_BITS'(Q_ONE) : dnd_r[QUAT_BITS-1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BE_IDLE: if (job_valid) st_nxt = copy_job ? BE_OUT : BE_NORM;
      BE_NORM: if (idx_r == 2'd3) st_nxt = (n_sum == '0) ? BE_OUT : BE_SQRT;
      BE_SQRT: if (cnt_r == SQ_LAST) st_nxt = BE_DIV;
      BE_DIV:  if (cnt_r == DIV_LAST && idx_r == 2'd3) st_nxt = BE_OUT;
      BE_OUT:  if (res_ready) st_nxt = BE_IDLE;
      default: st_nxt = BE_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    job_ready = (st_r == BE_IDLE);
    res_valid = (st_r == BE_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BE_IDLE;
    else        st_r <= st_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      BE_IDLE: begin
        if (job_valid) begin
          pos_r <= job_pos; mot_r <= job_mot; src_r <= job_src;
          q_r   <= job_att0;
          for (int i = 0; i < 4; i++)
            s_r[i*SB +: SB] <= SB'($signed(job_att0[i*QUAT_BITS +: QUAT_BITS])) +
                               SB'($signed(job_att1[i*QUAT_BITS +: QUAT_BITS]));
          n_r <= '0; idx_r <= '0; cnt_r <= '0;
        end
      end
      BE_NORM: begin
        n_r   <= n_sum;
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          // zero quaternion falls back to identity
          rad_r  <= {n_sum, 24'd0};
          root_r <= '0;
          rem_r  <= '0;
          cnt_r  <= '0;
          q_r    <= {QUAT_BITS'(Q_ONE), {(3*QUAT_BITS){1'b0}}};
        end
      end
      BE_SQRT: begin
        if (rt_hi >= rt_try) begin
          rem_r  <= (LB+2)'(rt_hi - rt_try);
          root_r <= {root_r[LB-2:0], 1'b1};
        end else begin
          rem_r  <= (LB+2)'(rt_hi);
          root_r <= {root_r[LB-2:0], 1'b0};
        end
        rad_r <= {rad_r[NB-3:0], 2'b00};
        cnt_r <= (cnt_r == SQ_LAST) ? '0 : cnt_r + 6'd1;
      end
      BE_DIV: begin
        cnt_r <= (cnt_r == DIV_LAST) ? '0 : cnt_r + 6'd1;
        if (cnt_r == '0) begin
          dnd_r <= (DB'(cur_abs) << 29) + DB'(root_r);
          rem_r <= '0;
        end else if (cnt_r == DIV_LAST) begin
          q_r[idx_r*QUAT_BITS +: QUAT_BITS] <= cur[SB-1] ? QUAT_BITS'(-k_val) : k_val;
          idx_r <= idx_r + 2'd1;
        end else begin
          rem_r <= dv_ge ? dv_sh - dv_den : dv_sh;
          dnd_r <= {dnd_r[DB-2:0], dv_ge};
        end
      end
      default: ;
    endcase
  end

  assign res_pos = pos_r;
  assign res_att = q_r;
  assign res_mot = mot_r;
  assign res_src = src_r;

  // job only taken when idle
  a_job_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_acc |-> st_r == BE_IDLE) else $error("job taken while busy");
  // result leaves only from output state
  a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_acc |=> st_r == BE_IDLE) else $error("result did not retire");
  // held result stays stable
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> $stable(q_r)) else $error("result changed");
  // held result stays valid
  a_res_keep: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");

endmodule

>>> sv/gated_pose_twist_fusion.sv
// ----------------------------------------------------------------------------
// gated_pose_twist_fusion: top level
// Samples and ticks enter a front end that stores and classifies them; a
// registered job hand-off feeds the normalization back end. A tick with one
// source is copied through the job register into the result register. With
// both sources the back end sums four squares, takes a bit-serial square
// root (32 steps) and runs four bit-serial divisions (load, 48 steps,
// write); a zero quaternion skips the root and divisions and gives the
// identity. The front keeps accepting samples while the back end works
// until a second tick waits behind the one in progress; a held result
// stalls the back end.
// ----------------------------------------------------------------------------
module gated_pose_twist_fusion
  import gptf_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int RATE_BITS     = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // req_type
  input  logic [1:0] in_tuser,
  // pos_x, pos_y, pos_z, quat_x..quat_w, speed_in, yaw_rate_in
  input  logic [((3*POSITION_BITS+4*QUAT_BITS+2*RATE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // source_used
  output logic [2:0] out_tuser,
  // fused_x..z, fused_qx..qw, fused_speed, fused_yaw_rate
  output logic [((3*POSITION_BITS+4*QUAT_BITS+2*RATE_BITS+7)/8)*8-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [TOL_BITS-1:0] cfg_data
);

  localparam int PB = POSITION_BITS;
  localparam int RB = RATE_BITS;
  localparam int QO = 3*PB;
  localparam int MO = 3*PB + 4*QUAT_BITS;
  localparam int DW = ((3*PB+4*QUAT_BITS+2*RB+7)/8)*8;

  logic [TOL_BITS-1:0]     spd_tol_r, yaw_tol_r;
  logic                    jv, jr;
  logic [3*PB-1:0]         jpos, rpos;
  logic [4*QUAT_BITS-1:0]  ja0, ja1, ratt;
  logic [2*RB-1:0]         jmot, rmot;
  logic [SRC_BITS-1:0]     jsrc;

  // tolerance registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_tol_r <= TOL_BITS'(2048);
      yaw_tol_r <= TOL_BITS'(3277);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SPEED_TOL) spd_tol_r <= cfg_data;
      else                            yaw_tol_r <= cfg_data;
    end
  end

  gptf_front #(.PB(PB), .RB(RB)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .req(in_tuser),
    .pos(in_tdata[QO-1:0]), .att(in_tdata[MO-1:QO]),
    .mot(in_tdata[MO+2*RB-1:MO]),
    .spd_tol(spd_tol_r), .yaw_tol(yaw_tol_r),
    .job_valid(jv), .job_ready(jr), .job_pos(jpos), .job_att0(ja0),
    .job_att1(ja1), .job_mot(jmot), .job_src(jsrc)
  );

  gptf_back #(.PB(PB), .RB(RB)) u_back (
    .clk, .rst_n,
    .job_valid(jv), .job_ready(jr), .job_pos(jpos), .job_att0(ja0),
    .job_att1(ja1), .job_mot(jmot), .job_src(jsrc),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_pos(rpos),
    .res_att(ratt), .res_mot(rmot), .res_src(out_tuser)
  );

  assign out_tdata = DW'({rmot, ratt, rpos});

endmodule
